### src/i2c_register_read_master_unit_assert.svh
// Assertion macros shared by the I2C register read master checker.
// Depends on a clock named clock and an active high reset named reset in scope.
`ifndef I2C_REGISTER_READ_MASTER_UNIT_ASSERT_SVH
`define I2C_REGISTER_READ_MASTER_UNIT_ASSERT_SVH

// Checked only outside reset.
`define I2CRM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked at every edge, reset included.
`define I2CRM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### src/i2crm_pkg.sv
// Package for the I2C register read master: payload types, codes and constants.
// Used by the front, back, top level and checker; depends on nothing.
package i2crm_pkg;

   localparam int unsigned BYTE_COUNT_MAX_DEFAULT = 255;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUARTER_DELAY  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STRETCH_LIMIT  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SETTLE_TICKS   = 2'd3;

   localparam logic [7:0]  DEVICE_ADDRESS_RESET = 8'd170;
   localparam logic [9:0]  QUARTER_DELAY_RESET  = 10'd10;
   localparam logic [15:0] STRETCH_LIMIT_RESET  = 16'd200;
   localparam logic [15:0] SETTLE_TICKS_RESET   = 16'd200;

   localparam logic [1:0] PORT_IDLE = 2'd0;
   localparam logic [1:0] PORT_ONE  = 2'd1;
   localparam logic [1:0] PORT_TWO  = 2'd2;

   localparam logic [1:0] STATUS_NONE     = 2'd0;
   localparam logic [1:0] STATUS_DONE     = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT  = 2'd2;
   localparam logic [1:0] STATUS_REJECTED = 2'd3;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic       kind;
      logic [1:0] port_select;
      logic [7:0] command_byte;
      logic [7:0] byte_count;
      logic       scl_in;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_release;
      logic       sda_release;
      logic [1:0] active_port;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       rx_last;
      logic       busy_res;
      logic [1:0] status;
      logic       nack_seen;
   } rsp_type;

   typedef struct packed {
      logic       start;
      logic       reject;
      logic [1:0] port_select;
      logic [7:0] command_byte;
      logic [7:0] byte_count;
      logic       scl_in;
      logic       sda_in;
   } tick_type;

endpackage

### src/i2crm_front.sv
// Front of the I2C register read master: classifies each tick and queues it.
// Depends on i2crm_pkg for the request and queued tick types.
module i2crm_front #(
   parameter int unsigned BYTE_COUNT_MAX = i2crm_pkg::BYTE_COUNT_MAX_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  i2crm_pkg::req_type   req_data,
   output logic                 tick_valid,
   input  logic                 tick_pop,
   output i2crm_pkg::tick_type  tick_data
);

   i2crm_pkg::tick_type entry_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   i2crm_pkg::tick_type classified;
   logic                port_ok;
   logic                push;
   logic                pop;

   always_comb begin
      port_ok = (req_data.port_select == i2crm_pkg::PORT_ONE) ||
                (req_data.port_select == i2crm_pkg::PORT_TWO);
      classified.start        = req_data.kind && port_ok;
      classified.reject       = req_data.kind && !port_ok;
      classified.port_select  = req_data.port_select;
      classified.command_byte = req_data.command_byte;
      classified.scl_in       = req_data.scl_in;
      classified.sda_in       = req_data.sda_in;
      classified.byte_count   = req_data.byte_count;
      if (req_data.byte_count == 8'd0) begin
         classified.byte_count = 8'd1;
      end
      if (32'(classified.byte_count) > BYTE_COUNT_MAX) begin
         classified.byte_count = 8'(BYTE_COUNT_MAX);
      end
   end

   assign req_ready  = (count_ff != 2'd2);
   assign tick_valid = (count_ff != 2'd0);
   assign tick_data  = entry_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = tick_pop && tick_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

### src/i2crm_back.sv
// Back of the I2C register read master: bus sequencer, settings and result register.
// Depends on i2crm_pkg; takes classified ticks from i2crm_front.
module i2crm_back (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_write_enable,
   input  logic [i2crm_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [i2crm_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata,
   input  logic                                      tick_valid,
   output logic                                      tick_pop,
   input  i2crm_pkg::tick_type                       tick_data,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output i2crm_pkg::rsp_type                        rsp_data
);

   typedef enum logic [4:0] {
      PH_IDLE, PH_SETTLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_ST_D,
      PH_TX_SETUP, PH_TX_HIGH, PH_TX_WAIT, PH_TX_LOW,
      PH_TA_REL, PH_TA_WAIT, PH_TA_SAMPLE,
      PH_RX_HIGH, PH_RX_WAIT, PH_RX_ACK, PH_RX_END,
      PH_SP_A, PH_SP_B, PH_SP_C, PH_FINISH
   } phase_type;

   localparam logic [1:0] STAGE_ADDRESS = 2'd0;
   localparam logic [1:0] STAGE_COMMAND = 2'd1;
   localparam logic [1:0] STAGE_READ    = 2'd2;

   logic [7:0]         device_address_ff;
   logic [9:0]         quarter_delay_ff;
   logic [15:0]        stretch_limit_ff;
   logic [15:0]        settle_ticks_ff;

   phase_type          phase_ff, phase_in;
   logic [15:0]        delay_ff, delay_in;
   logic [15:0]        stretch_ff, stretch_in;
   logic [3:0]         bit_count_ff, bit_count_in;
   logic [7:0]         shift_ff, shift_in;
   logic [7:0]         bytes_left_ff, bytes_left_in;
   logic [7:0]         held_command_ff, held_command_in;
   logic [1:0]         held_port_ff, held_port_in;
   logic               nack_ff, nack_in;
   logic [1:0]         tx_stage_ff, tx_stage_in;
   logic               timed_out_ff, timed_out_in;
   logic               scl_drv_ff, scl_drv_in;
   logic               sda_drv_ff, sda_drv_in;
   logic               rsp_valid_ff, rsp_valid_in;
   i2crm_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic               pop;
   logic               stretch_wait;
   logic               finished;
   logic               busy;
   logic [3:0]         bit_next;
   logic [7:0]         left_next;
   logic [15:0]        hold_ticks;

   assign pop       = tick_valid && (!rsp_valid_ff || rsp_ready);
   assign tick_pop  = pop;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      phase_in        = phase_ff;
      delay_in        = delay_ff;
      stretch_in      = stretch_ff;
      bit_count_in    = bit_count_ff;
      shift_in        = shift_ff;
      bytes_left_in   = bytes_left_ff;
      held_command_in = held_command_ff;
      held_port_in    = held_port_ff;
      nack_in         = nack_ff;
      tx_stage_in     = tx_stage_ff;
      timed_out_in    = timed_out_ff;
      scl_drv_in      = scl_drv_ff;
      sda_drv_in      = sda_drv_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      stretch_wait    = 1'b0;
      finished        = 1'b0;
      busy            = 1'b0;
      hold_ticks      = {6'd0, quarter_delay_ff};
      bit_next        = bit_count_ff + 4'd1;
      left_next       = (bytes_left_ff != 8'd0) ? bytes_left_ff - 8'd1 : 8'd0;

      if (pop) begin
         rsp_data_in          = '0;
         rsp_valid_in         = 1'b1;
         rsp_data_in.status   = i2crm_pkg::STATUS_NONE;
         if (phase_ff == PH_IDLE) begin
            if (tick_data.start) begin
               held_port_in    = tick_data.port_select;
               held_command_in = tick_data.command_byte;
               bytes_left_in   = tick_data.byte_count;
               nack_in         = 1'b0;
               timed_out_in    = 1'b0;
               tx_stage_in     = STAGE_ADDRESS;
               shift_in        = device_address_ff;
               bit_count_in    = 4'd0;
               scl_drv_in      = 1'b1;
               sda_drv_in      = 1'b1;
               phase_in        = PH_SETTLE;
               delay_in        = settle_ticks_ff;
            end else if (tick_data.reject) begin
               rsp_data_in.status = i2crm_pkg::STATUS_REJECTED;
            end
         end else if (delay_ff != 16'd0) begin
            delay_in = delay_ff - 16'd1;
         end else begin
            unique case (phase_ff)
               PH_SETTLE: begin
                  phase_in = PH_ST_A;
               end
               PH_ST_A: begin
                  sda_drv_in = 1'b1;
                  delay_in   = hold_ticks;
                  phase_in   = PH_ST_B;
               end
               PH_ST_B: begin
                  scl_drv_in = 1'b1;
                  delay_in   = hold_ticks;
                  phase_in   = PH_ST_C;
               end
               PH_ST_C: begin
                  sda_drv_in = 1'b0;
                  delay_in   = hold_ticks;
                  phase_in   = PH_ST_D;
               end
               PH_ST_D: begin
                  scl_drv_in   = 1'b0;
                  delay_in     = hold_ticks;
                  bit_count_in = 4'd0;
                  phase_in     = PH_TX_SETUP;
               end
               PH_TX_SETUP: begin
                  scl_drv_in = 1'b0;
                  sda_drv_in = shift_ff[7];
                  delay_in   = hold_ticks;
                  phase_in   = PH_TX_HIGH;
               end
               PH_TX_HIGH: begin
                  scl_drv_in = 1'b1;
                  stretch_in = 16'd0;
                  phase_in   = PH_TX_WAIT;
               end
               PH_TX_WAIT: begin
                  if (tick_data.scl_in) begin
                     delay_in = hold_ticks;
                     phase_in = PH_TX_LOW;
                  end else begin
                     stretch_wait = 1'b1;
                  end
               end
               PH_TX_LOW: begin
                  scl_drv_in   = 1'b0;
                  shift_in     = {shift_ff[6:0], 1'b0};
                  bit_count_in = bit_next;
                  if (bit_next >= i2crm_pkg::BITS_PER_BYTE) begin
                     delay_in = hold_ticks;
                     phase_in = PH_TA_REL;
                  end else begin
                     phase_in = PH_TX_SETUP;
                  end
               end
               PH_TA_REL: begin
                  sda_drv_in = 1'b1;
                  scl_drv_in = 1'b1;
                  stretch_in = 16'd0;
                  phase_in   = PH_TA_WAIT;
               end
               PH_TA_WAIT: begin
                  if (tick_data.scl_in) begin
                     delay_in = hold_ticks;
                     phase_in = PH_TA_SAMPLE;
                  end else begin
                     stretch_wait = 1'b1;
                  end
               end
               PH_TA_SAMPLE: begin
                  if (tick_data.sda_in) begin
                     nack_in = 1'b1;
                  end
                  scl_drv_in   = 1'b0;
                  delay_in     = hold_ticks;
                  bit_count_in = 4'd0;
                  if (tx_stage_ff == STAGE_ADDRESS) begin
                     tx_stage_in = STAGE_COMMAND;
                     shift_in    = held_command_ff;
                     phase_in    = PH_TX_SETUP;
                  end else if (tx_stage_ff == STAGE_COMMAND) begin
                     tx_stage_in = STAGE_READ;
                     shift_in    = device_address_ff + 8'd1;
                     phase_in    = PH_ST_A;
                  end else begin
                     shift_in = 8'd0;
                     phase_in = PH_RX_HIGH;
                  end
               end
               PH_RX_HIGH: begin
                  sda_drv_in = 1'b1;
                  scl_drv_in = 1'b1;
                  stretch_in = 16'd0;
                  phase_in   = PH_RX_WAIT;
               end
               PH_RX_WAIT: begin
                  if (tick_data.scl_in) begin
                     shift_in     = {shift_ff[6:0], tick_data.sda_in};
                     scl_drv_in   = 1'b0;
                     delay_in     = hold_ticks;
                     bit_count_in = bit_next;
                     phase_in     = (bit_next >= i2crm_pkg::BITS_PER_BYTE) ?
                                    PH_RX_ACK : PH_RX_HIGH;
                  end else begin
                     stretch_wait = 1'b1;
                  end
               end
               PH_RX_ACK: begin
                  sda_drv_in = (bytes_left_ff > 8'd1) ? 1'b0 : 1'b1;
                  scl_drv_in = 1'b1;
                  delay_in   = hold_ticks;
                  phase_in   = PH_RX_END;
               end
               PH_RX_END: begin
                  scl_drv_in           = 1'b0;
                  sda_drv_in           = 1'b1;
                  rsp_data_in.rx_valid = 1'b1;
                  rsp_data_in.rx_byte  = shift_ff;
                  rsp_data_in.rx_last  = (bytes_left_ff <= 8'd1);
                  bytes_left_in        = left_next;
                  shift_in             = 8'd0;
                  bit_count_in         = 4'd0;
                  delay_in             = hold_ticks;
                  phase_in             = (left_next == 8'd0) ? PH_SP_A : PH_RX_HIGH;
               end
               PH_SP_A: begin
                  scl_drv_in = 1'b0;
                  sda_drv_in = 1'b0;
                  delay_in   = hold_ticks;
                  phase_in   = PH_SP_B;
               end
               PH_SP_B: begin
                  scl_drv_in = 1'b1;
                  delay_in   = hold_ticks;
                  phase_in   = PH_SP_C;
               end
               PH_SP_C: begin
                  sda_drv_in = 1'b1;
                  delay_in   = hold_ticks;
                  phase_in   = PH_FINISH;
               end
               default: begin
                  rsp_data_in.status = timed_out_ff ? i2crm_pkg::STATUS_TIMEOUT :
                                                      i2crm_pkg::STATUS_DONE;
                  finished   = 1'b1;
                  scl_drv_in = 1'b1;
                  sda_drv_in = 1'b1;
                  phase_in   = PH_IDLE;
               end
            endcase
            if (stretch_wait) begin
               if (stretch_ff >= stretch_limit_ff) begin
                  timed_out_in = 1'b1;
                  scl_drv_in   = 1'b0;
                  phase_in     = PH_SP_A;
                  delay_in     = 16'd0;
               end else begin
                  stretch_in = stretch_ff + 16'd1;
               end
            end
         end
         busy                    = (phase_in != PH_IDLE);
         rsp_data_in.scl_release = scl_drv_in;
         rsp_data_in.sda_release = sda_drv_in;
         rsp_data_in.active_port = busy ? held_port_in : i2crm_pkg::PORT_IDLE;
         rsp_data_in.busy_res    = busy;
         rsp_data_in.nack_seen   = (busy || finished) ? nack_in : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= i2crm_pkg::DEVICE_ADDRESS_RESET;
         quarter_delay_ff  <= i2crm_pkg::QUARTER_DELAY_RESET;
         stretch_limit_ff  <= i2crm_pkg::STRETCH_LIMIT_RESET;
         settle_ticks_ff   <= i2crm_pkg::SETTLE_TICKS_RESET;
         phase_ff          <= PH_IDLE;
         delay_ff          <= 16'd0;
         stretch_ff        <= 16'd0;
         bit_count_ff      <= 4'd0;
         shift_ff          <= 8'd0;
         bytes_left_ff     <= 8'd0;
         held_command_ff   <= 8'd0;
         held_port_ff      <= 2'd0;
         nack_ff           <= 1'b0;
         tx_stage_ff       <= STAGE_ADDRESS;
         timed_out_ff      <= 1'b0;
         scl_drv_ff        <= 1'b1;
         sda_drv_ff        <= 1'b1;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               i2crm_pkg::CSR_DEVICE_ADDRESS: device_address_ff <= csr_wdata[7:0];
               i2crm_pkg::CSR_QUARTER_DELAY:  quarter_delay_ff  <= csr_wdata[9:0];
               i2crm_pkg::CSR_STRETCH_LIMIT:  stretch_limit_ff  <= csr_wdata;
               i2crm_pkg::CSR_SETTLE_TICKS:   settle_ticks_ff   <= csr_wdata;
               default: ;
            endcase
         end
         phase_ff        <= phase_in;
         delay_ff        <= delay_in;
         stretch_ff      <= stretch_in;
         bit_count_ff    <= bit_count_in;
         shift_ff        <= shift_in;
         bytes_left_ff   <= bytes_left_in;
         held_command_ff <= held_command_in;
         held_port_ff    <= held_port_in;
         nack_ff         <= nack_in;
         tx_stage_ff     <= tx_stage_in;
         timed_out_ff    <= timed_out_in;
         scl_drv_ff      <= scl_drv_in;
         sda_drv_ff      <= sda_drv_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### src/i2c_register_read_master_unit.sv
// I2C register read master. Each request item is one bus timing tick; every
// tick yields exactly one result item with the line drives and status. The
// block takes one tick per clock and sustains that rate while results are not
// stalled. Each tick passes a two-entry queue, which absorbs up to two ticks in
// a stall, from the tick classifier to the bus sequencer, which registers its
// result; the sequencer's per-tick step is one 16-bit count-down and compare. The
// user writes settings through the csr_ port only while no transaction is running;
// the block does not enforce this. Depends on i2crm_pkg, i2crm_front and i2crm_back.
module i2c_register_read_master_unit #(
   parameter int unsigned BYTE_COUNT_MAX = i2crm_pkg::BYTE_COUNT_MAX_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  i2crm_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output i2crm_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_write_enable,
   input  logic [i2crm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [i2crm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic                tick_valid;
   logic                tick_pop;
   i2crm_pkg::tick_type tick_data;

   i2crm_front #(
      .BYTE_COUNT_MAX (BYTE_COUNT_MAX)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .tick_valid (tick_valid),
      .tick_pop   (tick_pop),
      .tick_data  (tick_data)
   );

   i2crm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .tick_valid       (tick_valid),
      .tick_pop         (tick_pop),
      .tick_data        (tick_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data)
   );

endmodule

### src/i2crm_checker.sv
// Port-level checker for the I2C register read master, bound to the top level.
// Depends on i2crm_pkg and the assertion macros header.
`include "i2c_register_read_master_unit_assert.svh"

module i2crm_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input i2crm_pkg::rsp_type rsp_data
);

   logic rsp_stall;
   logic port_driven;
   logic status_event;
   logic rx_idle;
   logic rx_clear;

   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign port_driven  = (rsp_data.active_port != i2crm_pkg::PORT_IDLE);
   assign status_event = rsp_valid && (rsp_data.status != i2crm_pkg::STATUS_NONE);
   assign rx_idle      = rsp_valid && !rsp_data.rx_valid;
   assign rx_clear     = (rsp_data.rx_byte == 8'd0) && !rsp_data.rx_last;

   `I2CRM_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid && req_ready, "not empty after reset")
   `I2CRM_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_data), "result dropped")
   `I2CRM_ASSERT(a_port_busy, rsp_valid |-> rsp_data.busy_res == port_driven, "busy mismatch")
   `I2CRM_ASSERT(a_status_idle, status_event |-> !rsp_data.busy_res, "status while busy")
   `I2CRM_ASSERT(a_rx_clear, rx_idle |-> rx_clear, "stale receive data")

endmodule

bind i2c_register_read_master_unit i2crm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
